@@ hw/rtl/sensor_frame_crc_check_macros.svh @@
// assertion macros for the sensor frame crc checker
// used by the checker module; no other dependencies
`ifndef SENSOR_FRAME_CRC_CHECK_MACROS_SVH
`define SENSOR_FRAME_CRC_CHECK_MACROS_SVH

// property checked only while out of reset
`define SCFC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scfc assertion failed");

// property checked at every edge, reset included
`define SCFC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scfc assertion failed");

`endif

@@ hw/rtl/scfc_pkg.sv @@
// shared types and constants for the sensor frame crc checker
// no dependencies
package scfc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  // byte position codes within one reply frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       abort;
  } in_item_t;

  typedef struct packed {
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
    logic        frame_valid;
  } out_item_t;

  // result handed from the frame stage to the output register
  typedef struct packed {
    logic      hit;
    out_item_t item;
  } scfc_res_t;

endpackage

@@ hw/rtl/scfc_crc8.sv @@
// one byte step of crc-8, poly 0x31, msb first
// depends on scfc_pkg
module scfc_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);
  import scfc_pkg::*;

  logic [7:0] v;

  // eight shift steps flatten into a small xor network
  always_comb begin
    v = crc_in ^ data_in;
    for (int i = 0; i < 8; i++) begin
      if ((v & CRC_TOP) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    crc_out = v;
  end

endmodule

@@ hw/rtl/scfc_frame.sv @@
// input register and frame state: byte position, running crc, held words
// depends on scfc_pkg and scfc_crc8
module scfc_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  scfc_pkg::in_item_t  in_data,
  output logic                in_stall,
  input  logic                out_space,
  output logic                adv,
  output scfc_pkg::scfc_res_t res
);
  import scfc_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_data_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        ok_r, ok_nxt;
  logic [15:0] held_t_r, held_t_nxt;
  logic [15:0] held_h_r, held_h_nxt;
  logic [15:0] pend_t_r, pend_t_nxt;
  logic [7:0]  pend_h_r, pend_h_nxt;
  logic [7:0]  crc_step;
  logic        in_take;

  scfc_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (s1_data_r.rx_byte),
    .crc_out (crc_step)
  );

  // next frame state and result for the item in the input register
  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    ok_nxt     = ok_r;
    held_t_nxt = held_t_r;
    held_h_nxt = held_h_r;
    pend_t_nxt = pend_t_r;
    pend_h_nxt = pend_h_r;
    res.hit                  = 1'b0;
    res.item.temperature_raw = held_t_r;
    res.item.humidity_raw    = held_h_r;
    res.item.frame_valid     = 1'b0;
    if (s1_valid_r) begin
      if (s1_data_r.abort) begin
        pos_nxt = POS_T_MSB;
        crc_nxt = CRC_INIT;
        ok_nxt  = 1'b0;
        res.hit = 1'b1;
      end else begin
        case (pos_r)
          POS_T_MSB: begin
            pend_t_nxt = {s1_data_r.rx_byte, 8'h00};
            crc_nxt    = crc_step;
            pos_nxt    = POS_T_LSB;
          end
          POS_T_LSB: begin
            pend_t_nxt = {pend_t_r[15:8], s1_data_r.rx_byte};
            crc_nxt    = crc_step;
            pos_nxt    = POS_T_CRC;
          end
          POS_T_CRC: begin
            ok_nxt  = (crc_r == s1_data_r.rx_byte);
            crc_nxt = CRC_INIT;
            pos_nxt = POS_H_MSB;
          end
          POS_H_MSB: begin
            pend_h_nxt = s1_data_r.rx_byte;
            crc_nxt    = crc_step;
            pos_nxt    = POS_H_LSB;
          end
          POS_H_LSB: begin
            crc_nxt    = crc_step;
            held_h_nxt = {pend_h_r, s1_data_r.rx_byte};
            pos_nxt    = POS_H_CRC;
          end
          POS_H_CRC: begin
            held_t_nxt = pend_t_r;
            pos_nxt    = POS_T_MSB;
            crc_nxt    = CRC_INIT;
            ok_nxt     = 1'b0;
            res.hit                  = 1'b1;
            res.item.temperature_raw = pend_t_r;
            res.item.frame_valid     = ok_r && (crc_r == s1_data_r.rx_byte);
          end
          default: begin
            pos_nxt = POS_T_MSB;
            crc_nxt = CRC_INIT;
            ok_nxt  = 1'b0;
          end
        endcase
      end
    end
  end

  // item leaves the input register unless its result finds no room
  assign adv      = s1_valid_r && (!res.hit || out_space);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!s1_valid_r || adv) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= POS_T_MSB;
      crc_r      <= CRC_INIT;
      ok_r       <= 1'b0;
      held_t_r   <= 16'h0000;
      held_h_r   <= 16'h0000;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (adv) begin
        pos_r    <= pos_nxt;
        crc_r    <= crc_nxt;
        ok_r     <= ok_nxt;
        held_t_r <= held_t_nxt;
        held_h_r <= held_h_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      pend_t_r <= pend_t_nxt;
      pend_h_r <= pend_h_nxt;
    end
  end

endmodule

@@ hw/rtl/scfc_out_reg.sv @@
// result register on the out channel
// depends on scfc_pkg
module scfc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  scfc_pkg::scfc_res_t res,
  output logic                out_space,
  output logic                out_valid,
  output scfc_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import scfc_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      load;

  assign out_space = !out_valid_r || !out_stall;
  assign load      = adv && res.hit;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/sensor_frame_crc_check.sv @@
// top level of the sensor reply frame crc checker
// depends on scfc_pkg, scfc_frame, scfc_crc8 and scfc_out_reg
// usage:
//   in channel: one received reply byte per transaction, six bytes a frame:
//   temperature msb, lsb, crc, then humidity msb, lsb, crc. a transaction
//   with abort set (address not acked) ignores its byte and restarts the frame
//   out channel: one transaction per complete frame or per abort, carrying
//   the raw temperature and humidity words and frame_valid, which is set
//   only when both crc-8 checks (poly 0x31, init 0xff, msb first) pass;
//   an abort returns the last held words with frame_valid low
//   note: the humidity word is taken at its lsb byte, so an abort on the
//   humidity crc byte already reports the new humidity word
//   path: an accepted byte is registered in the input register, and its
//   result (if any) is registered in the output register
//   throughput: one byte per cycle unless a result is held by out_stall; the
//   crc step is an xor network from the input register to the running crc register
//   stall: a stalled result holds in the output register; a byte with a result
//   behind it waits in the input register and in_stall rises only then
//   reset: synchronous, clears both valid flags, restarts the frame and
//   clears the held words to zero
module sensor_frame_crc_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  scfc_pkg::in_item_t  in_data,
  output logic                in_stall,
  output logic                out_valid,
  output scfc_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import scfc_pkg::*;

  // result of the frame stage, and its move into the output register
  scfc_res_t res;
  logic      adv;
  logic      out_space;

  // input register, frame state and crc step
  scfc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_space (out_space),
    .adv       (adv),
    .res       (res)
  );

  // result register, frees up in the same cycle it is taken
  scfc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .res       (res),
    .out_space (out_space),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

@@ hw/rtl/scfc_checker.sv @@
// port level checks for sensor_frame_crc_check, bound to the top level
// depends on scfc_pkg and sensor_frame_crc_check_macros.svh
`include "sensor_frame_crc_check_macros.svh"

module scfc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input scfc_pkg::in_item_t  in_data,
  input logic                in_stall,
  input logic                out_valid,
  input scfc_pkg::out_item_t out_data,
  input logic                out_stall
);
  import scfc_pkg::*;

  // a stalled result stays and holds its payload
  `SCFC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

  // reset leaves both sides empty and ready
  `SCFC_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid && !in_stall)

  // the input side waits only behind a stalled result
  `SCFC_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall)

  // a fresh result comes from an accepted transaction that passed the input register
  `SCFC_ASSERT(a_rise_src, clk, rst_n, $rose(out_valid) |-> $past(in_valid && !in_stall, 2))

endmodule

bind sensor_frame_crc_check scfc_checker u_scfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_data   (in_data),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);
